// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the bgl_checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BGL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BGL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/bgl_pkg.sv =====
// ---------------------------------------------------------------------------
// bgl_pkg
// Types shared by the binary gcd / lcm unit and its arithmetic unit.
// ---------------------------------------------------------------------------
package bgl_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_XODD,
    ST_LOOP,
    ST_SHIFT,
    ST_DIV,
    ST_MUL
  } bgl_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } bgl_alu_op_t;

endpackage

// ===== hw/rtl/bgl_alu.sv =====
// ---------------------------------------------------------------------------
// bgl_alu
// Shared adder/subtractor with carry (add) or borrow (subtract) out.
// ---------------------------------------------------------------------------
module bgl_alu #(
  parameter int WIDTH = 65
) (
  input  bgl_pkg::bgl_alu_op_t op,
  input  logic [WIDTH-1:0]     op_a,
  input  logic [WIDTH-1:0]     op_b,
  output logic [WIDTH-1:0]     res,
  output logic                 carry
);

  logic [WIDTH:0] ext;

  always_comb begin
    if (op == bgl_pkg::ALU_ADD) begin
      ext = {1'b0, op_a} + {1'b0, op_b};
    end else begin
      ext = {1'b0, op_a} - {1'b0, op_b};
    end
  end

  assign res   = ext[WIDTH-1:0];
  assign carry = ext[WIDTH];

endmodule

// ===== hw/rtl/binary_gcd_lcm_unit.sv =====
// ---------------------------------------------------------------------------
// binary_gcd_lcm_unit
// Stein binary gcd with lcm = (a / gcd) * b, saturating on overflow.
// ---------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  command  | operand_a, operand_b                    | start & !busy
//  result   | gcd_value, lcm_value, lcm_overflow      | done, one-cycle strobe
//
// A zero operand gives its word on the cycle after acceptance.
// Otherwise: common trailing zeros (twice, strip and restore), odd strip of a,
// the subtract/shift loop, then the restoring divide and the shift-add
// multiply, all on one adder. Synchronous reset clears the sequencer and the
// strobe. The result is not held off: done pulses once and busy is already low
// in that cycle.
// ---------------------------------------------------------------------------
module binary_gcd_lcm_unit #(
  parameter int DATA_BITS = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [DATA_BITS-1:0] operand_a,
  input  logic [DATA_BITS-1:0] operand_b,
  output logic                 done,
  output logic [DATA_BITS-1:0] gcd_value,
  output logic [DATA_BITS-1:0] lcm_value,
  output logic                 lcm_overflow
);

  localparam int W  = DATA_BITS + 2;
  localparam int CW = $clog2(DATA_BITS);
  localparam logic [CW-1:0] LAST = CW'(DATA_BITS - 1);

  bgl_pkg::bgl_state_t state, state_next;

  logic [DATA_BITS-1:0] a_reg, a_reg_next, b_reg, b_reg_next;
  logic [DATA_BITS-1:0] x, x_next, y, y_next;
  logic [DATA_BITS-1:0] rem, rem_next, quo, quo_next, prod, prod_next;
  logic                 movf, movf_next, movf_step;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 done_next, lcm_overflow_next;
  logic [DATA_BITS-1:0] gcd_value_next, lcm_value_next;

  bgl_pkg::bgl_alu_op_t alu_op;
  logic [W-1:0]         alu_a, alu_b, alu_res;
  logic                 alu_carry;

  bgl_alu #(.WIDTH(W)) u_alu (
    .op    (alu_op),
    .op_a  (alu_a),
    .op_b  (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign busy = (state != bgl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgl_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    a_reg        <= a_reg_next;
    b_reg        <= b_reg_next;
    x            <= x_next;
    y            <= y_next;
    rem          <= rem_next;
    quo          <= quo_next;
    prod         <= prod_next;
    movf         <= movf_next;
    cnt          <= cnt_next;
    gcd_value    <= gcd_value_next;
    lcm_value    <= lcm_value_next;
    lcm_overflow <= lcm_overflow_next;
  end

  always_comb begin
    state_next        = state;
    a_reg_next        = a_reg;
    b_reg_next        = b_reg;
    x_next            = x;
    y_next            = y;
    rem_next          = rem;
    quo_next          = quo;
    prod_next         = prod;
    movf_next         = movf;
    movf_step         = movf;
    cnt_next          = cnt;
    done_next         = 1'b0;
    gcd_value_next    = gcd_value;
    lcm_value_next    = lcm_value;
    lcm_overflow_next = lcm_overflow;
    alu_op            = bgl_pkg::ALU_SUB;
    alu_a             = '0;
    alu_b             = '0;

    case (state)
      bgl_pkg::ST_IDLE: begin
        if (start) begin
          a_reg_next = operand_a;
          b_reg_next = operand_b;
          x_next     = operand_a;
          y_next     = operand_b;
          cnt_next   = '0;
          if (operand_a == '0 || operand_b == '0) begin
            done_next         = 1'b1;
            gcd_value_next    = operand_a | operand_b;
            lcm_value_next    = '0;
            lcm_overflow_next = 1'b0;
          end else begin
            state_next = bgl_pkg::ST_TWOS;
          end
        end
      end

      bgl_pkg::ST_TWOS: begin
        if (x[0] || y[0]) begin
          state_next = bgl_pkg::ST_XODD;
        end else begin
          x_next   = x >> 1;
          y_next   = y >> 1;
          cnt_next = cnt + 1'b1;
        end
      end

      bgl_pkg::ST_XODD: begin
        if (x[0]) begin
          state_next = bgl_pkg::ST_LOOP;
        end else begin
          x_next = x >> 1;
        end
      end

      bgl_pkg::ST_LOOP: begin
        alu_a = {2'b00, y};
        alu_b = {2'b00, x};
        if (!y[0]) begin
          y_next = y >> 1;
        end else if (alu_carry) begin
          // y below x: swap, subtract on the next cycle
          x_next = y;
          y_next = x;
        end else if (alu_res[DATA_BITS-1:0] == '0) begin
          state_next = bgl_pkg::ST_SHIFT;
        end else begin
          y_next = alu_res[DATA_BITS-1:0];
        end
      end

      bgl_pkg::ST_SHIFT: begin
        if (cnt == '0) begin
          state_next = bgl_pkg::ST_DIV;
          rem_next   = '0;
          quo_next   = a_reg;
        end else begin
          x_next   = x << 1;
          cnt_next = cnt - 1'b1;
        end
      end

      bgl_pkg::ST_DIV: begin
        // restoring divide a / gcd, quotient shifts in behind the dividend
        alu_a = {1'b0, rem, quo[DATA_BITS-1]};
        alu_b = {2'b00, x};
        if (!alu_carry) begin
          rem_next = alu_res[DATA_BITS-1:0];
          quo_next = {quo[DATA_BITS-2:0], 1'b1};
        end else begin
          rem_next = {rem[DATA_BITS-2:0], quo[DATA_BITS-1]};
          quo_next = {quo[DATA_BITS-2:0], 1'b0};
        end
        if (cnt == LAST) begin
          state_next = bgl_pkg::ST_MUL;
          cnt_next   = '0;
          prod_next  = '0;
          movf_next  = 1'b0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      bgl_pkg::ST_MUL: begin
        // quotient msb first: p = 2p + bit*b; overflow is sticky
        alu_op    = bgl_pkg::ALU_ADD;
        alu_a     = {1'b0, prod, 1'b0};
        alu_b     = quo[DATA_BITS-1] ? {2'b00, b_reg} : '0;
        quo_next  = {quo[DATA_BITS-2:0], 1'b0};
        prod_next = alu_res[DATA_BITS-1:0];
        movf_step = movf | (alu_res[W-1:DATA_BITS] != '0);
        movf_next = movf_step;
        if (cnt == LAST) begin
          state_next        = bgl_pkg::ST_IDLE;
          done_next         = 1'b1;
          gcd_value_next    = x;
          lcm_value_next    = movf_step ? '1 : alu_res[DATA_BITS-1:0];
          lcm_overflow_next = movf_step;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = bgl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bgl_checker.sv =====
// ---------------------------------------------------------------------------
// bgl_checker
// Port-level checks on the gcd / lcm unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bgl_checker #(
  parameter int DATA_BITS = 63
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [DATA_BITS-1:0] operand_a,
  input logic [DATA_BITS-1:0] operand_b,
  input logic                 done,
  input logic [DATA_BITS-1:0] gcd_value,
  input logic [DATA_BITS-1:0] lcm_value,
  input logic                 lcm_overflow
);

  // a word is only ever delivered with the unit free
  `BGL_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)

  `BGL_ASSERT_NOW(a_ovf_sat, clk, rst, done && lcm_overflow, lcm_value == '1)

  // gcd of zero only when both operands were zero
  `BGL_ASSERT_NOW(a_zero_lcm, clk, rst, done && gcd_value == '0,
                  lcm_value == '0 && !lcm_overflow)

  `BGL_ASSERT_NEXT(a_work_busy, clk, rst,
                   start && !busy && operand_a != '0 && operand_b != '0, busy && !done)

endmodule

bind binary_gcd_lcm_unit bgl_checker #(.DATA_BITS(DATA_BITS)) u_bgl_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operand_a    (operand_a),
  .operand_b    (operand_b),
  .done         (done),
  .gcd_value    (gcd_value),
  .lcm_value    (lcm_value),
  .lcm_overflow (lcm_overflow)
);

// ===== verif/gcd_lcm_checker.sv =====
// ---------------------------------------------------------------------------
// gcd_lcm_checker
// Watches the command and result channels of the binary gcd / lcm unit,
// predicts gcd, lcm and overflow for every accepted command word and
// compares each result word with the oldest prediction.
// ---------------------------------------------------------------------------
module gcd_lcm_checker #(
  parameter int DATA_BITS = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [DATA_BITS-1:0] operand_a,
  input  logic [DATA_BITS-1:0] operand_b,
  input  logic                 done,
  input  logic [DATA_BITS-1:0] gcd_value,
  input  logic [DATA_BITS-1:0] lcm_value,
  input  logic                 lcm_overflow,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [DATA_BITS-1:0] word_t;

  typedef struct {
    word_t a;
    word_t b;
    word_t gcd;
    word_t lcm;
    logic  ovf;
  } gcd_lcm_word_t;

  localparam word_t WORD_MAX = '1;

  gcd_lcm_word_t gcd_lcm_q[$];
  int            errors = 0;

  assign fail_count = errors;
  assign pending    = gcd_lcm_q.size();

  function automatic word_t stein_gcd(word_t x, word_t y);
    word_t t;
    int    twos;
    if (x == '0 || y == '0) begin
      return x | y;
    end
    twos = 0;
    while (x[0] == 1'b0 && y[0] == 1'b0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) begin
      x = x >> 1;
    end
    // x odd from here on; y reduced to odd, then difference taken
    do begin
      while (y[0] == 1'b0) begin
        y = y >> 1;
      end
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end while (y != '0);
    return x << twos;
  endfunction

  function automatic gcd_lcm_word_t predict_gcd_lcm(word_t a, word_t b);
    gcd_lcm_word_t w;
    word_t         quot;
    w.a   = a;
    w.b   = b;
    w.gcd = stein_gcd(a, b);
    w.lcm = '0;
    w.ovf = 1'b0;
    if (a != '0 && b != '0) begin
      quot = a / w.gcd;
      if (quot > WORD_MAX / b) begin
        w.lcm = WORD_MAX;
        w.ovf = 1'b1;
      end else begin
        w.lcm = quot * b;
      end
    end
    return w;
  endfunction

  task automatic report(string field, word_t got, word_t want, gcd_lcm_word_t w);
    $display("checker: %s mismatch a=%0d b=%0d got %0d want %0d",
             field, w.a, w.b, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    gcd_lcm_word_t w;
    if (!rst) begin
      if (start && !busy) begin
        gcd_lcm_q.insert(gcd_lcm_q.size(), predict_gcd_lcm(operand_a, operand_b));
      end
      if (done) begin
        if (gcd_lcm_q.size() == 0) begin
          w.a = 'x;
          w.b = 'x;
          report("unexpected word", gcd_value, '0, w);
        end else begin
          w = gcd_lcm_q.pop_front();
          if (gcd_value !== w.gcd) report("gcd_value", gcd_value, w.gcd, w);
          if (lcm_value !== w.lcm) report("lcm_value", lcm_value, w.lcm, w);
          if (lcm_overflow !== w.ovf) begin
            report("lcm_overflow", word_t'(lcm_overflow), word_t'(w.ovf), w);
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives command words into the binary gcd / lcm unit: a directed set of
// corner operands, then random words shaped for shared factors, large factors of
// two, near-overflow products and zero operands, with random idle gaps.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW             = 63;
  localparam int RANDOM_WORDS   = 750;
  localparam int DRAIN_CYCLES   = 400;
  localparam int TIMEOUT_CYCLES = 1_200_000;

  typedef logic [DW-1:0] word_t;

  localparam word_t WORD_MAX = '1;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  start     = 1'b0;
  word_t operand_a = '0;
  word_t operand_b = '0;
  logic  busy;
  logic  done;
  word_t gcd_value;
  word_t lcm_value;
  logic  lcm_overflow;
  int    fail_count;
  int    pending;
  int    cycles   = 0;
  int    idle_max = 17;

  binary_gcd_lcm_unit #(.DATA_BITS(DW)) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .gcd_value    (gcd_value),
    .lcm_value    (lcm_value),
    .lcm_overflow (lcm_overflow)
  );

  gcd_lcm_checker #(.DATA_BITS(DW)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .gcd_value    (gcd_value),
    .lcm_value    (lcm_value),
    .lcm_overflow (lcm_overflow),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic word_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[DW-1:0];
  endfunction

  // one command word; start stays high across back-to-back words
  task automatic issue(word_t a, word_t b);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic pick_operands(output word_t a, output word_t b);
    word_t g;
    word_t x;
    word_t y;
    int    w;
    case ($urandom_range(0, 9))
      0, 1: begin
        a = rand_word();
        b = rand_word();
      end
      2, 3: begin
        // shared factor g, cofactors sized so the products still fit
        w = $urandom_range(1, DW - 1);
        g = rand_word() >> (DW - w);
        x = rand_word() >> (w + $urandom_range(0, DW - 1 - w));
        y = rand_word() >> (w + $urandom_range(0, DW - 1 - w));
        a = g * x;
        b = g * y;
      end
      4: begin
        a = rand_word() << $urandom_range(0, DW - 1);
        b = rand_word() << $urandom_range(0, DW - 1);
      end
      5: begin
        a = word_t'($urandom_range(0, 1000));
        b = word_t'($urandom_range(0, 1000));
      end
      6: begin
        a = $urandom_range(0, 1) ? '0 : rand_word() >> $urandom_range(0, DW - 1);
        b = $urandom_range(0, 1) ? '0 : rand_word() >> $urandom_range(0, DW - 1);
      end
      7: begin
        // one divides the other
        a = rand_word() >> $urandom_range(10, DW - 1);
        b = a * word_t'($urandom_range(1, 1000));
        if ($urandom_range(0, 1)) begin
          g = a;
          a = b;
          b = g;
        end
      end
      8: begin
        // products around the top of the range
        a = word_t'($urandom) + word_t'($urandom_range(0, 1) ? 32'h8000_0000 : 0);
        b = word_t'($urandom);
      end
      default: begin
        a = rand_word() >> $urandom_range(0, DW - 1);
        b = rand_word() >> $urandom_range(0, DW - 1);
      end
    endcase
  endtask

  initial begin
    word_t a;
    word_t b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    issue('0, '0);
    issue('0, WORD_MAX);
    issue(WORD_MAX, '0);
    issue('0, 63'd12);
    issue(63'd1, 63'd1);
    issue(WORD_MAX, WORD_MAX);
    issue(63'd1, WORD_MAX);
    issue(WORD_MAX, 63'd1);
    issue(WORD_MAX, WORD_MAX - 1);
    issue(63'd1 << 62, 63'd1 << 62);
    issue(63'd1 << 62, 63'd3);
    issue(63'd1 << 62, 63'd1);
    issue(63'd6, 63'd4);
    issue(63'd48, 63'd180);
    issue(63'd17, 63'd17 << 40);
    issue(WORD_MAX / 63'd73, 63'd73);     // lcm lands exactly on the maximum
    issue(WORD_MAX / 63'd73, 63'd146);    // twice it: the lcm overflows and saturates
    issue(63'd3037000499, 63'd3037000493);
    issue(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5554);
    issue(63'd1 << 31, (63'd1 << 32) + 63'd1);
    wait_quiet();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 0) begin
        idle_max = (idle_max == 0) ? 17 : 0;
      end
      if (i == RANDOM_WORDS / 2) begin
        wait_quiet();
      end
      pick_operands(a, b);
      issue(a, b);
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bgl_pkg.sv
hw/rtl/bgl_alu.sv
hw/rtl/binary_gcd_lcm_unit.sv
hw/rtl/bgl_checker.sv
verif/gcd_lcm_checker.sv
verif/testbench.sv
